[design/ppurp_pkg.sv]
// Package for the PPU register port: beat types, register selects, request codes.
// No dependencies.
package ppurp_pkg;

   localparam int OamBytes       = 256;
   localparam int PatternBytes   = 8192;
   localparam int NametableBytes = 2048;
   localparam int PaletteBytes   = 32;

   localparam logic [1:0] REQ_READ   = 2'd0;
   localparam logic [1:0] REQ_PEEK   = 2'd1;
   localparam logic [1:0] REQ_WRITE  = 2'd2;
   localparam logic [1:0] REQ_STATUS = 2'd3;

   localparam logic [2:0] SEL_CONTROL = 3'd0;
   localparam logic [2:0] SEL_MASK    = 3'd1;
   localparam logic [2:0] SEL_STATUS  = 3'd2;
   localparam logic [2:0] SEL_OAMADDR = 3'd3;
   localparam logic [2:0] SEL_OAMDATA = 3'd4;
   localparam logic [2:0] SEL_SCROLL  = 3'd5;
   localparam logic [2:0] SEL_ADDR    = 3'd6;
   localparam logic [2:0] SEL_DATA    = 3'd7;

   typedef struct packed {
      logic [1:0] req_type;
      logic [2:0] register_select;
      logic [7:0] write_data;
   } req_type_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [15:0] vram_address;
      logic [14:0] temp_address;
      logic [2:0]  fine_x_scroll;
      logic [7:0]  control_bits;
      logic [7:0]  mask_bits;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;  // latch the request and launch memory reads
      logic execute;  // apply the access, memory data now valid
   } cmd_type;

endpackage

[design/ppu_register_port_core.sv]
// Top level of the PPU register port.
// Depends on ppurp_pkg, ppurp_ctrl and ppurp_dp.
//
// Each request beat is one CPU access to the eight picture-processor registers
// (read, peek or write) or a status update from the renderer, and it yields
// exactly one response beat carrying the read byte and the renderer-facing
// registers as they stand after the access. The accepting edge captures the
// request and issues the registered memory read at v; the next edge applies the
// access with the read data in hand. The response is valid from then on and is
// held until it is taken. The controller returns to idle only once the response
// is taken, so a new request beat is not accepted before the previous response
// has left. The mirroring mode may be written only while idle. Memories
// come up undefined; reading an entry before writing it returns garbage.
module ppu_register_port_core #(
   parameter int OAM_BYTES       = ppurp_pkg::OamBytes,
   parameter int PATTERN_BYTES   = ppurp_pkg::PatternBytes,
   parameter int NAMETABLE_BYTES = ppurp_pkg::NametableBytes
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ppurp_pkg::req_type_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ppurp_pkg::rsp_type      rsp_data,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data
);
   import ppurp_pkg::*;

   cmd_type cmd;

   // The controller sequences each beat; the datapath holds all state.
   ppurp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .cmd);

   ppurp_dp #(
      .OAM_BYTES(OAM_BYTES), .PATTERN_BYTES(PATTERN_BYTES),
      .NAMETABLE_BYTES(NAMETABLE_BYTES)
   ) u_dp (
      .clock, .reset, .cmd, .req(req_data), .csr_write_enable, .csr_write_data,
      .rsp(rsp_data));
endmodule

[design/ppurp_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module ppurp_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

[design/ppurp_ctrl.sv]
// Controller for the PPU register port: capture, execute, respond.
// Depends on ppurp_pkg.
module ppurp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ppurp_pkg::cmd_type  cmd
);
   import ppurp_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

[design/ppurp_dp.sv]
// Datapath for the PPU register port: registers, address logic and memories.
// Depends on ppurp_pkg and ppurp_ram.
module ppurp_dp #(
   parameter int OAM_BYTES       = ppurp_pkg::OamBytes,
   parameter int PATTERN_BYTES   = ppurp_pkg::PatternBytes,
   parameter int NAMETABLE_BYTES = ppurp_pkg::NametableBytes
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ppurp_pkg::cmd_type      cmd,
   input  ppurp_pkg::req_type_type req,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   output ppurp_pkg::rsp_type      rsp
);
   import ppurp_pkg::*;

   localparam int OamW = $clog2(OAM_BYTES);
   localparam int PatW = $clog2(PATTERN_BYTES);
   localparam int NtW  = $clog2(NAMETABLE_BYTES);
   localparam int PalW = $clog2(PaletteBytes);

   req_type_type req_ff;
   logic        mirror_ff;
   logic [7:0]  control_ff, mask_ff, read_buffer_ff, oam_pointer_ff, read_data_ff;
   logic [2:0]  status_ff, fine_x_ff;
   logic [15:0] v_ff;
   logic [14:0] t_ff;
   logic        toggle_ff;

   // The VRAM address comes from v at capture; v only changes at execute.
   logic [13:0] bus_addr;
   logic        is_pat, is_nt, is_pal;
   logic        nt_sel;
   logic [4:0]  pal_raw;
   logic [PalW-1:0] pal_idx;
   logic        data_wr;

   assign bus_addr = v_ff[13:0];
   assign is_pat   = (bus_addr < 14'h2000);
   assign is_pal   = (bus_addr >= 14'h3F00);
   assign is_nt    = !is_pat && !is_pal;
   assign nt_sel   = mirror_ff ? bus_addr[11] : bus_addr[10];
   assign pal_raw  = bus_addr[4:0];
   assign pal_idx  = ((pal_raw & 5'h13) == 5'h10) ? PalW'(pal_raw & 5'h0F) : PalW'(pal_raw);
   assign data_wr  = cmd.execute && req_ff.req_type == REQ_WRITE
                     && req_ff.register_select == SEL_DATA;

   logic [7:0] oam_q, pat_q, nt_q, pal_q;

   ppurp_ram #(.Width(8), .Depth(OAM_BYTES)) u_oam (
      .clock, .wr_en(cmd.execute && req_ff.req_type == REQ_WRITE
                     && req_ff.register_select == SEL_OAMDATA),
      .addr(oam_pointer_ff[OamW-1:0]), .wr_data(req_ff.write_data), .rd_data(oam_q));
   ppurp_ram #(.Width(8), .Depth(PATTERN_BYTES)) u_pat (
      .clock, .wr_en(data_wr && is_pat), .addr(bus_addr[PatW-1:0]),
      .wr_data(req_ff.write_data), .rd_data(pat_q));
   ppurp_ram #(.Width(8), .Depth(NAMETABLE_BYTES)) u_nt (
      .clock, .wr_en(data_wr && is_nt), .addr(NtW'({nt_sel, bus_addr[9:0]})),
      .wr_data(req_ff.write_data), .rd_data(nt_q));
   ppurp_ram #(.Width(8), .Depth(PaletteBytes)) u_pal (
      .clock, .wr_en(data_wr && is_pal), .addr(pal_idx),
      .wr_data(req_ff.write_data), .rd_data(pal_q));

   logic [7:0]  bus_q;
   logic [15:0] v_step;
   assign bus_q  = is_pat ? pat_q : is_nt ? nt_q : (pal_q & (mask_ff[0] ? 8'h30 : 8'h3F));
   assign v_step = v_ff + (control_ff[2] ? 16'd32 : 16'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff <= 1'b0;
      end else if (csr_write_enable) begin
         mirror_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
      end
      if (reset) begin
         control_ff     <= '0;
         mask_ff        <= '0;
         status_ff      <= '0;
         v_ff           <= '0;
         t_ff           <= '0;
         fine_x_ff      <= '0;
         toggle_ff      <= 1'b0;
         read_buffer_ff <= '0;
         oam_pointer_ff <= '0;
         read_data_ff   <= '0;
      end else if (cmd.execute) begin
         read_data_ff <= '0;
         case (req_ff.req_type)
            REQ_READ: begin
               case (req_ff.register_select)
                  SEL_STATUS: begin
                     read_data_ff <= {status_ff, read_buffer_ff[4:0]};
                     status_ff[2] <= 1'b0;
                     toggle_ff    <= 1'b0;
                  end
                  SEL_OAMDATA: read_data_ff <= oam_q;
                  SEL_DATA: begin
                     read_data_ff   <= is_pal ? bus_q : read_buffer_ff;
                     read_buffer_ff <= bus_q;
                     v_ff           <= v_step;
                  end
                  default: ;
               endcase
            end
            REQ_PEEK: begin
               case (req_ff.register_select)
                  SEL_CONTROL: read_data_ff <= control_ff;
                  SEL_MASK:    read_data_ff <= mask_ff;
                  SEL_STATUS:  read_data_ff <= {status_ff, 5'b0};
                  default: ;
               endcase
            end
            REQ_WRITE: begin
               case (req_ff.register_select)
                  SEL_CONTROL: begin
                     control_ff   <= req_ff.write_data;
                     t_ff[11:10]  <= req_ff.write_data[1:0];
                  end
                  SEL_MASK:    mask_ff        <= req_ff.write_data;
                  SEL_OAMADDR: oam_pointer_ff <= req_ff.write_data;
                  SEL_SCROLL: begin
                     if (!toggle_ff) begin
                        fine_x_ff <= req_ff.write_data[2:0];
                        t_ff[4:0] <= req_ff.write_data[7:3];
                     end else begin
                        t_ff[14:12] <= req_ff.write_data[2:0];
                        t_ff[9:5]   <= req_ff.write_data[7:3];
                     end
                     toggle_ff <= !toggle_ff;
                  end
                  SEL_ADDR: begin
                     if (!toggle_ff) begin
                        t_ff[14:8] <= {1'b0, req_ff.write_data[5:0]};
                     end else begin
                        t_ff[7:0] <= req_ff.write_data;
                        v_ff      <= {1'b0, t_ff[14:8], req_ff.write_data};
                     end
                     toggle_ff <= !toggle_ff;
                  end
                  SEL_DATA: v_ff <= v_step;
                  default: ;
               endcase
            end
            REQ_STATUS: status_ff <= req_ff.write_data[7:5];
            default: ;
         endcase
      end
   end

   assign rsp.read_data     = read_data_ff;
   assign rsp.vram_address  = v_ff;
   assign rsp.temp_address  = t_ff;
   assign rsp.fine_x_scroll = fine_x_ff;
   assign rsp.control_bits  = control_ff;
   assign rsp.mask_bits     = mask_ff;
endmodule

[tb/ppu_register_port_core_tb.sv]
// Self-checking testbench for ppu_register_port_core, the PPU CPU register port.
// Depends on ppurp_pkg and on the design files of ppu_register_port_core.
// A predictor of the register port works out the expected response for each beat.
`timescale 1ns / 1ps

module ppu_register_port_core_tb;
   import ppurp_pkg::*;

   localparam int CycleLimit  = 1000000;
   localparam int RandomBeats = 1200;
   localparam int PaletteBase = PatternBytes + NametableBytes;
   localparam int VramSlots   = PaletteBase + PaletteBytes;

   typedef struct {
      logic [1:0] req;
      logic [2:0] sel;
      logic [7:0] wd;
      bit         typed;
      rsp_type    rsp;
   } table_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_type_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_type      rsp_data;
   logic         csr_write_enable;
   logic         csr_write_data;

   // Predicted register file of the port.
   logic        pr_mirror;
   logic [7:0]  pr_control;
   logic [7:0]  pr_mask;
   logic [2:0]  pr_status;
   logic [15:0] pr_v;
   logic [14:0] pr_t;
   logic [2:0]  pr_fine_x;
   logic        pr_toggle;
   logic [7:0]  pr_buffer;
   logic [7:0]  pr_oam_ptr;
   // Predicted memories, with a flag per entry that marks it as written.
   logic [7:0]  oam_image [OamBytes];
   bit          oam_written [OamBytes];
   logic [7:0]  vram_image [VramSlots];
   bit          vram_written [VramSlots];

   rsp_type       pending_rsp[$];
   table_row_type directed_rows[$];
   int            errors;
   int            cycles;
   int            beats_sent;
   int            rsp_stall;

   ppu_register_port_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Idle length for either side: half the time none, often short, now and then long.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Maps a PPU bus address onto one flat space: pattern bytes first, then the
   // two physical nametables, then the 32 palette entries with their fold-down.
   function automatic int vram_slot(logic [15:0] addr);
      logic [13:0] a;
      logic [4:0]  p;
      logic        nt_sel;
      a = addr[13:0];
      if (a < 14'h2000) return int'(a);
      if (a < 14'h3F00) begin
         nt_sel = pr_mirror ? a[11] : a[10];
         return PatternBytes + int'(nt_sel) * 1024 + int'(a[9:0]);
      end
      p = a[4:0];
      if (p[4] && p[1:0] == 2'b00) p[4] = 1'b0;
      return PaletteBase + int'(p);
   endfunction

   // True unless the beat would read a memory entry that was never written.
   function automatic bit reads_written_entry(req_type_type b);
      if (b.req_type != REQ_READ) return 1'b1;
      if (b.register_select == SEL_OAMDATA) return oam_written[pr_oam_ptr];
      if (b.register_select == SEL_DATA) return vram_written[vram_slot(pr_v)];
      return 1'b1;
   endfunction

   function automatic void advance_v();
      pr_v = pr_v + (pr_control[2] ? 16'd32 : 16'd1);
   endfunction

   // Applies one beat to the predicted state and returns the response it yields.
   function automatic rsp_type port_access(req_type_type b);
      rsp_type r;
      logic [7:0] d;
      int slot;
      d = 8'h00;
      case (b.req_type)
         REQ_READ: begin
            case (b.register_select)
               SEL_STATUS: begin
                  d = {pr_status, pr_buffer[4:0]};
                  pr_status[2] = 1'b0;
                  pr_toggle = 1'b0;
               end
               SEL_OAMDATA: d = oam_image[pr_oam_ptr];
               SEL_DATA: begin
                  // The data port answers from the buffer, except in the palette
                  // region, where the fresh byte comes back at once.
                  slot = vram_slot(pr_v);
                  d = pr_buffer;
                  pr_buffer = vram_image[slot];
                  if (slot >= PaletteBase) pr_buffer &= pr_mask[0] ? 8'h30 : 8'h3F;
                  if (pr_v[13:0] >= 14'h3F00) d = pr_buffer;
                  advance_v();
               end
               default: d = 8'h00;
            endcase
         end
         REQ_PEEK: begin
            case (b.register_select)
               SEL_CONTROL: d = pr_control;
               SEL_MASK:    d = pr_mask;
               SEL_STATUS:  d = {pr_status, 5'b00000};
               default:     d = 8'h00;
            endcase
         end
         REQ_WRITE: begin
            d = b.write_data;
            case (b.register_select)
               SEL_CONTROL: begin
                  pr_control = d;
                  pr_t[11:10] = d[1:0];
               end
               SEL_MASK:    pr_mask = d;
               SEL_OAMADDR: pr_oam_ptr = d;
               SEL_OAMDATA: begin
                  oam_image[pr_oam_ptr] = d;
                  oam_written[pr_oam_ptr] = 1'b1;
               end
               SEL_SCROLL: begin
                  if (!pr_toggle) begin
                     pr_fine_x = d[2:0];
                     pr_t[4:0] = d[7:3];
                  end else begin
                     pr_t[14:12] = d[2:0];
                     pr_t[9:5] = d[7:3];
                  end
                  pr_toggle = !pr_toggle;
               end
               SEL_ADDR: begin
                  if (!pr_toggle) begin
                     pr_t[14] = 1'b0;
                     pr_t[13:8] = d[5:0];
                  end else begin
                     pr_t[7:0] = d;
                     pr_v = {1'b0, pr_t};
                  end
                  pr_toggle = !pr_toggle;
               end
               SEL_DATA: begin
                  slot = vram_slot(pr_v);
                  vram_image[slot] = d;
                  vram_written[slot] = 1'b1;
                  advance_v();
               end
               default: ;
            endcase
            d = 8'h00;
         end
         default: pr_status = b.write_data[7:5];
      endcase
      r.read_data     = d;
      r.vram_address  = pr_v;
      r.temp_address  = pr_t;
      r.fine_x_scroll = pr_fine_x;
      r.control_bits  = pr_control;
      r.mask_bits     = pr_mask;
      return r;
   endfunction

   // Sends one request beat after a random idle gap. A beat that would read an
   // unwritten entry is turned into a peek so that it stays inside the contract.
   task automatic send_beat(logic [1:0] req, logic [2:0] sel, logic [7:0] wd,
                            bit typed = 1'b0, rsp_type typed_rsp = '0);
      req_type_type b;
      rsp_type      predicted;
      int           gap;
      b.req_type = req;
      b.register_select = sel;
      b.write_data = wd;
      if (!reads_written_entry(b)) b.req_type = REQ_PEEK;
      predicted = port_access(b);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      // Allow a margin once every response beat is back.
      repeat (6) @(posedge clock);
   endtask

   task automatic write_mirror(logic mode);
      csr_write_enable <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pr_mirror = mode;
   endtask

   task automatic add_row(logic [1:0] req, logic [2:0] sel, logic [7:0] wd,
                          bit typed = 1'b0, rsp_type rsp = '0);
      table_row_type row;
      row.req = req;
      row.sel = sel;
      row.wd = wd;
      row.typed = typed;
      row.rsp = rsp;
      directed_rows.push_back(row);
   endtask

   // Picks a bus address in one of the three regions, nametable mirrors included.
   function automatic logic [13:0] pick_address();
      case ($urandom_range(0, 2))
         0:       return 14'($urandom_range(0, 14'h1FFF));
         1:       return 14'($urandom_range(14'h2000, 14'h3EFF));
         default: return 14'($urandom_range(14'h3F00, 14'h3FFF));
      endcase
   endfunction

   // A well-formed data-port run: set the address, write a burst, set it again
   // and read the burst back through the buffer.
   task automatic data_burst();
      logic [13:0] a;
      int n;
      a = pick_address();
      n = $urandom_range(1, 6);
      if ($urandom_range(0, 3) == 0)
         send_beat(REQ_WRITE, SEL_CONTROL, 8'($urandom_range(0, 255)));
      for (int pass = 0; pass < 2; pass++) begin
         send_beat(REQ_READ, SEL_STATUS, 8'($urandom_range(0, 255)));
         send_beat(REQ_WRITE, SEL_ADDR, {2'($urandom_range(0, 3)), a[13:8]});
         send_beat(REQ_WRITE, SEL_ADDR, a[7:0]);
         for (int i = 0; i < n + pass; i++) begin
            if (pass == 0) send_beat(REQ_WRITE, SEL_DATA, 8'($urandom_range(0, 255)));
            else send_beat(REQ_READ, SEL_DATA, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic oam_burst();
      logic [7:0] p;
      p = 8'($urandom_range(0, 255));
      send_beat(REQ_WRITE, SEL_OAMADDR, p);
      send_beat(REQ_WRITE, SEL_OAMDATA, 8'($urandom_range(0, 255)));
      send_beat(REQ_READ, SEL_OAMDATA, 8'($urandom_range(0, 255)));
      send_beat(REQ_PEEK, SEL_OAMDATA, 8'($urandom_range(0, 255)));
   endtask

   task automatic noise_beat();
      send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)));
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Response side: random stalls on ready, and each beat taken is compared
   // with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               errors++;
               $display("%0t: response beat with nothing expected, actual %h",
                        $time, rsp_data);
            end else begin
               want = pending_rsp.pop_front();
               check_field("read_data", 16'(want.read_data), 16'(rsp_data.read_data));
               check_field("vram_address", want.vram_address, rsp_data.vram_address);
               check_field("temp_address", 16'(want.temp_address),
                           16'(rsp_data.temp_address));
               check_field("fine_x_scroll", 16'(want.fine_x_scroll),
                           16'(rsp_data.fine_x_scroll));
               check_field("control_bits", 16'(want.control_bits),
                           16'(rsp_data.control_bits));
               check_field("mask_bits", 16'(want.mask_bits), 16'(rsp_data.mask_bits));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall = idle_cycles();
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [1:0] r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      errors = 0;
      cycles = 0;
      beats_sent = 0;
      rsp_stall = 0;
      pr_mirror = 1'b0;
      pr_control = '0;
      pr_mask = '0;
      pr_status = '0;
      pr_v = '0;
      pr_t = '0;
      pr_fine_x = '0;
      pr_toggle = 1'b0;
      pr_buffer = '0;
      pr_oam_ptr = '0;
      foreach (oam_written[i]) oam_written[i] = 1'b0;
      foreach (vram_written[i]) vram_written[i] = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mirror(1'b0);

      // Directed part. Typed rows carry values read straight off the register
      // behavior; the rest go through the predictor.
      add_row(REQ_PEEK, SEL_CONTROL, 8'h00, 1, '{8'h00, 16'h0, 15'h0, 3'h0, 8'h00, 8'h00});
      add_row(REQ_READ, SEL_STATUS, 8'h00, 1, '{8'h00, 16'h0, 15'h0, 3'h0, 8'h00, 8'h00});
      add_row(REQ_READ, SEL_CONTROL, 8'hFF, 1, '{8'h00, 16'h0, 15'h0, 3'h0, 8'h00, 8'h00});
      add_row(REQ_WRITE, SEL_CONTROL, 8'hFF, 1,
              '{8'h00, 16'h0, 15'h0C00, 3'h0, 8'hFF, 8'h00});
      add_row(REQ_WRITE, SEL_MASK, 8'hFF, 1, '{8'h00, 16'h0, 15'h0C00, 3'h0, 8'hFF, 8'hFF});
      add_row(REQ_WRITE, SEL_CONTROL, 8'h00, 1, '{8'h00, 16'h0, 15'h0, 3'h0, 8'h00, 8'hFF});
      add_row(REQ_STATUS, SEL_DATA, 8'hFF, 1, '{8'h00, 16'h0, 15'h0, 3'h0, 8'h00, 8'hFF});
      add_row(REQ_PEEK, SEL_STATUS, 8'h00, 1, '{8'hE0, 16'h0, 15'h0, 3'h0, 8'h00, 8'hFF});
      add_row(REQ_READ, SEL_STATUS, 8'h00, 1, '{8'hE0, 16'h0, 15'h0, 3'h0, 8'h00, 8'hFF});
      add_row(REQ_PEEK, SEL_STATUS, 8'h00, 1, '{8'h60, 16'h0, 15'h0, 3'h0, 8'h00, 8'hFF});
      add_row(REQ_WRITE, SEL_STATUS, 8'hFF);   // ignored
      add_row(REQ_PEEK, SEL_DATA, 8'h00);      // peeks beyond status read zero
      add_row(REQ_WRITE, SEL_SCROLL, 8'hFF);
      add_row(REQ_WRITE, SEL_SCROLL, 8'hFF);
      add_row(REQ_WRITE, SEL_ADDR, 8'hFF);     // high byte clears t bit 14
      add_row(REQ_WRITE, SEL_ADDR, 8'h10);     // palette mirror of entry zero
      add_row(REQ_WRITE, SEL_DATA, 8'hFF);
      add_row(REQ_WRITE, SEL_ADDR, 8'h3F);
      add_row(REQ_WRITE, SEL_ADDR, 8'h00);
      add_row(REQ_READ, SEL_DATA, 8'h00);      // grayscale masks the palette byte
      add_row(REQ_WRITE, SEL_MASK, 8'h00);
      add_row(REQ_WRITE, SEL_OAMADDR, 8'hFF);
      add_row(REQ_WRITE, SEL_OAMDATA, 8'hA5);
      add_row(REQ_READ, SEL_OAMDATA, 8'h00);   // pointer does not move
      add_row(REQ_READ, SEL_OAMADDR, 8'h00);   // write-only, reads zero
      foreach (directed_rows[i])
         send_beat(directed_rows[i].req, directed_rows[i].sel, directed_rows[i].wd,
                   directed_rows[i].typed, directed_rows[i].rsp);

      // Random part, split into phases over both mirroring modes.
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         write_mirror(ph[0] ? 1'b1 : 1'b0);
         while (beats_sent < (ph + 1) * RandomBeats / 4 + directed_rows.size()) begin
            r = 2'($urandom_range(0, 3));
            if (r < 2) data_burst();
            else if (r == 2) oam_burst();
            else noise_beat();
            // In one short window of the run the sender waits for every response after each step.
            if (ph == 1 && beats_sent > RandomBeats / 3 && beats_sent < RandomBeats / 3 + 8)
               drain();
         end
      end
      drain();
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
